>>> rtl/hde_pkg.sv
`default_nettype none
package hde_pkg;

  localparam int unsigned LANES      = 4;
  localparam int unsigned ELEM_W     = 16;
  localparam int unsigned ACC_W      = 48;
  localparam int unsigned TERM_W     = 42;
  localparam int unsigned ROOT_W     = 12;
  localparam int unsigned RAD_W      = 2 * ROOT_W;
  localparam int unsigned QUO_W      = 40;
  localparam int unsigned CNT_W      = 6;

  typedef enum logic [1:0] {
    MODE_L1      = 2'd0,
    MODE_L2SQ    = 2'd1,
    MODE_HELL    = 2'd2,
    MODE_CHISQ   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    L_IDLE,
    L_ROOT,
    L_SQ,
    L_DIVLD,
    L_DIV,
    L_DONE
  } lane_state_t;

  typedef enum logic [1:0] {
    C_IDLE,
    C_BUSY,
    C_EMIT
  } ctl_state_t;

  typedef struct packed {
    logic add;
    logic clear;
  } acc_ctl_t;

endpackage
`default_nettype wire

>>> rtl/hde_if.sv
`default_nettype none
interface hde_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] v_lane0;
  logic signed [15:0] v_lane1;
  logic signed [15:0] v_lane2;
  logic signed [15:0] v_lane3;
  logic signed [15:0] u_lane0;
  logic signed [15:0] u_lane1;
  logic signed [15:0] u_lane2;
  logic signed [15:0] u_lane3;
  logic        [2:0]  lanes_valid;
  logic               last;

  modport source (output valid, v_lane0, v_lane1, v_lane2, v_lane3,
                  u_lane0, u_lane1, u_lane2, u_lane3, lanes_valid, last,
                  input ready);
  modport sink   (input valid, v_lane0, v_lane1, v_lane2, v_lane3,
                  u_lane0, u_lane1, u_lane2, u_lane3, lanes_valid, last,
                  output ready);
endinterface

interface hde_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] distance;
  logic               saturated;

  modport source (output valid, distance, saturated, input ready);
  modport sink   (input valid, distance, saturated, output ready);
endinterface
`default_nettype wire

>>> rtl/hde_lane.sv
`default_nettype none
module hde_lane
  import hde_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire mode_t                    mode,
  input  wire logic signed [ELEM_W-1:0] a,
  input  wire logic signed [ELEM_W-1:0] b,
  output logic                          done,
  output logic signed [TERM_W-1:0]      term
);

  typedef struct packed {
    logic [ROOT_W+2:0] rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
  } root_st_t;

  function automatic root_st_t root_step(input root_st_t s);
    root_st_t          r;
    logic [ROOT_W+2:0] tmp;
    logic [ROOT_W+2:0] trial;
    tmp   = {s.rem[ROOT_W:0], s.rad[RAD_W-1 -: 2]};
    trial = {1'b0, s.root, 2'b01};
    r.rad = {s.rad[RAD_W-3:0], 2'b00};
    if (tmp >= trial) begin
      r.rem  = tmp - trial;
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = tmp;
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [RAD_W-1:0] radicand(input logic signed [ELEM_W-1:0] x);
    logic [RAD_W-1:0] r;
    r = '0;
    if (!x[ELEM_W-1] && (x != '0)) begin
      r = {1'b0, x[ELEM_W-2:0], 8'h00};
    end
    return r;
  endfunction

  lane_state_t             state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic signed [ELEM_W-1:0] a_r, a_nxt, b_r, b_nxt;
  root_st_t                ra_r, ra_nxt, rb_r, rb_nxt;
  logic [31:0]             sq_r, sq_nxt;
  logic [QUO_W-1:0]        quo_r, quo_nxt;
  logic [ELEM_W:0]         rem_r, rem_nxt;

  logic signed [ELEM_W:0]  d, s;
  logic [ELEM_W:0]         d_neg, s_abs, divisor;
  logic [ELEM_W-1:0]       d_abs;
  logic signed [ROOT_W:0]  h;
  logic [ROOT_W:0]         h_neg;
  logic [ELEM_W-1:0]       sq_op;
  logic [ELEM_W+1:0]       rem2;
  logic signed [TERM_W-1:0] quo_s;

  always_comb begin
    d       = {a_r[ELEM_W-1], a_r} - {b_r[ELEM_W-1], b_r};
    s       = {a_r[ELEM_W-1], a_r} + {b_r[ELEM_W-1], b_r};
    d_neg   = -d;
    d_abs   = d[ELEM_W] ? d_neg[ELEM_W-1:0] : d[ELEM_W-1:0];
    s_abs   = s[ELEM_W] ? -s : s;
    divisor = (s == '0) ? (ELEM_W+1)'(256) : s_abs;
    h       = {1'b0, ra_r.root} - {1'b0, rb_r.root};
    h_neg   = -h;
    sq_op   = (mode == MODE_HELL)
            ? {{(ELEM_W-ROOT_W){1'b0}}, (h[ROOT_W] ? h_neg[ROOT_W-1:0] : h[ROOT_W-1:0])}
            : d_abs;
    rem2    = {rem_r, quo_r[QUO_W-1]};
    quo_s   = {{(TERM_W-QUO_W){1'b0}}, quo_r};
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    ra_nxt    = ra_r;
    rb_nxt    = rb_r;
    sq_nxt    = sq_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    done      = 1'b0;
    unique case (state_r)
      L_IDLE: begin
        if (start) begin
          a_nxt     = a;
          b_nxt     = b;
          ra_nxt    = '{rem: '0, root: '0, rad: radicand(a)};
          rb_nxt    = '{rem: '0, root: '0, rad: radicand(b)};
          cnt_nxt   = CNT_W'(ROOT_W - 1);
          state_nxt = L_ROOT;
        end
      end
      L_ROOT: begin
        ra_nxt  = root_step(ra_r);
        rb_nxt  = root_step(rb_r);
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = L_SQ;
        end
      end
      L_SQ: begin
        sq_nxt    = sq_op * sq_op;
        state_nxt = (mode == MODE_CHISQ) ? L_DIVLD : L_DONE;
      end
      L_DIVLD: begin
        quo_nxt   = {sq_r, 8'h00};
        rem_nxt   = '0;
        cnt_nxt   = CNT_W'(QUO_W - 1);
        state_nxt = L_DIV;
      end
      L_DIV: begin
        // restoring divide, one quotient bit a cycle
        if (rem2 >= {1'b0, divisor}) begin
          rem_nxt = (ELEM_W+1)'(rem2 - {1'b0, divisor});
          quo_nxt = {quo_r[QUO_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem2[ELEM_W:0];
          quo_nxt = {quo_r[QUO_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = L_DONE;
        end
      end
      L_DONE: begin
        done      = 1'b1;
        state_nxt = L_IDLE;
      end
      default: begin
        state_nxt = L_IDLE;
      end
    endcase
  end

  always_comb begin
    case (mode)
      MODE_L1:    term = {{(TERM_W-ELEM_W-8){1'b0}}, d_abs, 8'h00};
      MODE_CHISQ: term = s[ELEM_W] ? -quo_s : quo_s;
      default:    term = {{(TERM_W-32){1'b0}}, sq_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cnt_r <= cnt_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    ra_r  <= ra_nxt;
    rb_r  <= rb_nxt;
    sq_r  <= sq_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/hde_merge.sv
`default_nettype none
module hde_merge
  import hde_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire acc_ctl_t                 ctl,
  input  wire logic [LANES-1:0]         lane_mask,
  input  wire logic signed [TERM_W-1:0] terms [LANES],
  output logic signed [ACC_W-1:0]       acc,
  output logic                          clip
);

  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic                    clip_r, clip_nxt;
  logic signed [ACC_W:0]   total, sum;

  always_comb begin
    total = '0;
    for (int k = 0; k < LANES; k++) begin
      if (lane_mask[k]) begin
        total = total + {{(ACC_W+1-TERM_W){terms[k][TERM_W-1]}}, terms[k]};
      end
    end
    sum      = {acc_r[ACC_W-1], acc_r} + total;
    acc_nxt  = acc_r;
    clip_nxt = clip_r;
    if (ctl.clear) begin
      acc_nxt  = '0;
      clip_nxt = 1'b0;
    end else if (ctl.add) begin
      if (sum[ACC_W] != sum[ACC_W-1]) begin
        // clamp to the bound crossed
        acc_nxt  = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        clip_nxt = 1'b1;
      end else begin
        acc_nxt = sum[ACC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      clip_r <= 1'b0;
    end else begin
      acc_r  <= acc_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign acc  = acc_r;
  assign clip = clip_r;

endmodule
`default_nettype wire

>>> rtl/histogram_distance_engine.sv
// Each request runs through the 12-step root iteration and, in chi-square, the 40-step
//   divider inside each lane before its terms are added to the accumulator.
// A new request is accepted only once the lanes have finished the previous one; after the
//   request marked last, also only once the result has been handed to the output
//   register, which waits for that register to be free.
// Reset (rst_n, synchronous, active low): accumulator and clip flag cleared,
//   output empty, mode_r set to squared L2.
`default_nettype none
module histogram_distance_engine
  import hde_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  hde_in_if.sink     in_ch,
  hde_out_if.source  out_ch,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_wdata
);

  // distance mode register
  mode_t mode_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_L2SQ;
    end else if (cfg_we) begin
      mode_r <= mode_t'(cfg_wdata);
    end
  end

  ctl_state_t              state_r, state_nxt;
  logic [LANES-1:0]        mask_r, mask_nxt;
  logic                    last_r, last_nxt;
  logic                    accept;
  logic [LANES-1:0]        lane_done;
  logic signed [TERM_W-1:0] terms [LANES];
  logic signed [ELEM_W-1:0] va [LANES];
  logic signed [ELEM_W-1:0] ua [LANES];
  acc_ctl_t                acc_ctl;
  logic signed [ACC_W-1:0] acc;
  logic                    clip;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [ACC_W-1:0] dist_r, dist_nxt;
  logic                    sat_r, sat_nxt;
  logic                    out_free;

  assign va[0] = in_ch.v_lane0;
  assign va[1] = in_ch.v_lane1;
  assign va[2] = in_ch.v_lane2;
  assign va[3] = in_ch.v_lane3;
  assign ua[0] = in_ch.u_lane0;
  assign ua[1] = in_ch.u_lane1;
  assign ua[2] = in_ch.u_lane2;
  assign ua[3] = in_ch.u_lane3;

  assign in_ch.ready = (state_r == C_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // one lane per element pair; all lanes start together and finish together
  for (genvar k = 0; k < LANES; k++) begin : g_lane
    hde_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .start (accept),
      .mode  (mode_r),
      .a     (va[k]),
      .b     (ua[k]),
      .done  (lane_done[k]),
      .term  (terms[k])
    );
  end

  hde_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (acc_ctl),
    .lane_mask (mask_r),
    .terms     (terms),
    .acc       (acc),
    .clip      (clip)
  );

  always_comb begin
    state_nxt     = state_r;
    mask_nxt      = mask_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    dist_nxt      = dist_r;
    sat_nxt       = sat_r;
    acc_ctl       = '{add: 1'b0, clear: 1'b0};
    // drop the result once taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      C_IDLE: begin
        if (accept) begin
          // lanes_valid above the lane count acts as all lanes
          for (int k = 0; k < LANES; k++) begin
            mask_nxt[k] = (in_ch.lanes_valid > 3'(k));
          end
          last_nxt  = in_ch.last;
          state_nxt = C_BUSY;
        end
      end
      C_BUSY: begin
        if (&lane_done) begin
          acc_ctl.add = 1'b1;
          state_nxt   = last_r ? C_EMIT : C_IDLE;
        end
      end
      C_EMIT: begin
        // hold until the output register is free, then hand off and clear
        if (out_free) begin
          out_valid_nxt = 1'b1;
          dist_nxt      = acc;
          sat_nxt       = clip;
          acc_ctl.clear = 1'b1;
          state_nxt     = C_IDLE;
        end
      end
      default: begin
        state_nxt = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= C_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mask_r <= mask_nxt;
    last_r <= last_nxt;
    dist_r <= dist_nxt;
    sat_r  <= sat_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.distance  = dist_r;
  assign out_ch.saturated = sat_r;

endmodule
`default_nettype wire
